FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL of the pixel write address block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/pwag_pkg.sv
// ----------------------------------------------------------------------------
// pwag_pkg
// Types and constants of the pixel write address generator
// ----------------------------------------------------------------------------
package pwag_pkg;

    // parameter defaults
    localparam int COORD_BITS_DEF  = 11;
    localparam int OFFSET_BITS_DEF = 24;

    // fixed field widths
    localparam int VALUE_BITS    = 24;
    localparam int WIDTH_BITS    = 12;
    localparam int BASE_BITS     = 8;
    localparam int NUM_BUFS      = 4;
    localparam int BUF_SEL_BITS  = 2;
    localparam int COUNT_BITS    = 32;
    localparam int FRAME_BITS    = 8;
    localparam int ADDR_BITS     = 32;
    localparam int DATA_BITS     = 32;
    localparam int OUT_TDATA_BITS = ADDR_BITS + DATA_BITS + COUNT_BITS;

    // configuration port
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    // register indexes, byte address is 4 * index
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_BASE_HIGH_0   = 3'd0,
        REG_BASE_HIGH_1   = 3'd1,
        REG_BASE_HIGH_2   = 3'd2,
        REG_BASE_HIGH_3   = 3'd3,
        REG_ACTIVE_BUFFER = 3'd4,
        REG_IMAGE_WIDTH   = 3'd5,
        REG_FRAME_PIXELS  = 3'd6
    } reg_idx_t;

    // configuration handed from the register file to the datapath
    typedef struct packed {
        logic [NUM_BUFS-1:0][BASE_BITS-1:0] base_high;
        logic [BUF_SEL_BITS-1:0]            active_buffer;
        logic [WIDTH_BITS-1:0]              image_width;
        logic [COUNT_BITS-1:0]              frame_pixels;
    } pwag_cfg_t;

endpackage

FILE: src/pwag_regs.sv
// ----------------------------------------------------------------------------
// pwag_regs
// APB register file holding the frame buffer bases, active buffer, width and frame total
// ----------------------------------------------------------------------------
module pwag_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pwag_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [pwag_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [pwag_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output pwag_pkg::pwag_cfg_t                 cfg
);

    logic [pwag_pkg::NUM_BUFS-1:0][pwag_pkg::BASE_BITS-1:0] base_high_reg;
    logic [pwag_pkg::BUF_SEL_BITS-1:0]                      active_buffer_reg;
    logic [pwag_pkg::WIDTH_BITS-1:0]                        image_width_reg;
    logic [pwag_pkg::COUNT_BITS-1:0]                        frame_pixels_reg;
    pwag_pkg::reg_idx_t                                     reg_idx;
    logic                                                   wr_en;

    assign pready  = 1'b1;
    assign reg_idx = pwag_pkg::reg_idx_t'(paddr[pwag_pkg::APB_ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_high_reg     <= '0;
            active_buffer_reg <= '0;
            image_width_reg   <= '0;
            frame_pixels_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pwag_pkg::REG_BASE_HIGH_0:
                    base_high_reg[0] <= pwdata[pwag_pkg::BASE_BITS-1:0];
                pwag_pkg::REG_BASE_HIGH_1:
                    base_high_reg[1] <= pwdata[pwag_pkg::BASE_BITS-1:0];
                pwag_pkg::REG_BASE_HIGH_2:
                    base_high_reg[2] <= pwdata[pwag_pkg::BASE_BITS-1:0];
                pwag_pkg::REG_BASE_HIGH_3:
                    base_high_reg[3] <= pwdata[pwag_pkg::BASE_BITS-1:0];
                pwag_pkg::REG_ACTIVE_BUFFER:
                    active_buffer_reg <= pwdata[pwag_pkg::BUF_SEL_BITS-1:0];
                pwag_pkg::REG_IMAGE_WIDTH:
                    image_width_reg <= pwdata[pwag_pkg::WIDTH_BITS-1:0];
                pwag_pkg::REG_FRAME_PIXELS:
                    frame_pixels_reg <= pwdata[pwag_pkg::COUNT_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            pwag_pkg::REG_BASE_HIGH_0:
                prdata = pwag_pkg::APB_DATA_BITS'(base_high_reg[0]);
            pwag_pkg::REG_BASE_HIGH_1:
                prdata = pwag_pkg::APB_DATA_BITS'(base_high_reg[1]);
            pwag_pkg::REG_BASE_HIGH_2:
                prdata = pwag_pkg::APB_DATA_BITS'(base_high_reg[2]);
            pwag_pkg::REG_BASE_HIGH_3:
                prdata = pwag_pkg::APB_DATA_BITS'(base_high_reg[3]);
            pwag_pkg::REG_ACTIVE_BUFFER:
                prdata = pwag_pkg::APB_DATA_BITS'(active_buffer_reg);
            pwag_pkg::REG_IMAGE_WIDTH:
                prdata = pwag_pkg::APB_DATA_BITS'(image_width_reg);
            pwag_pkg::REG_FRAME_PIXELS:
                prdata = pwag_pkg::APB_DATA_BITS'(frame_pixels_reg);
            default:
                prdata = '0;
        endcase
    end

    // configuration bundle
    assign cfg.base_high     = base_high_reg;
    assign cfg.active_buffer = active_buffer_reg;
    assign cfg.image_width   = image_width_reg;
    assign cfg.frame_pixels  = frame_pixels_reg;

endmodule

FILE: src/pixel_write_address_generator.sv
// ----------------------------------------------------------------------------
// pixel_write_address_generator
// Turns a pixel stream into memory writes with frame and pixel counting
// ----------------------------------------------------------------------------
// One memory write leaves for every pixel item, one item per clock sustained
// while the output does not stall. An item passes an input register and then
// a result register, and its write is offered from the result register; the
// row * width multiply-add and the write count update sit between those two
// registers. A stalled output holds its write while the input register still
// takes the next pixel, and the block stops taking pixels only when both
// registers are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_write_address_generator
#(
    parameter int COORD_BITS  = pwag_pkg::COORD_BITS_DEF,
    parameter int OFFSET_BITS = pwag_pkg::OFFSET_BITS_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    // pixel items
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // pixel_row, pixel_col, pixel_value, zero fill
    input  logic [((2*COORD_BITS+pwag_pkg::VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // image_start
    input  logic                                        s_tuser,
    // write items
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // write_address, write_data, pixels_done
    output logic [pwag_pkg::OUT_TDATA_BITS-1:0]         m_tdata,
    // frame_done
    output logic                                        m_tuser,
    // configuration
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [pwag_pkg::APB_ADDR_BITS-1:0]          paddr,
    input  logic [pwag_pkg::APB_DATA_BITS-1:0]          pwdata,
    output logic [pwag_pkg::APB_DATA_BITS-1:0]          prdata,
    output logic                                        pready
);

    localparam int ROW_LO  = 0;
    localparam int COL_LO  = COORD_BITS;
    localparam int VAL_LO  = 2 * COORD_BITS;
    localparam int PROD_W  = COORD_BITS + pwag_pkg::WIDTH_BITS;
    localparam int SUM_W   = PROD_W + 1;
    localparam int SHIFT_W = SUM_W + 2;
    localparam int WIDE_A  = (SHIFT_W > OFFSET_BITS + pwag_pkg::BASE_BITS) ?
                             SHIFT_W : OFFSET_BITS + pwag_pkg::BASE_BITS;
    localparam int WIDE_W  = (WIDE_A > pwag_pkg::ADDR_BITS) ? WIDE_A : pwag_pkg::ADDR_BITS;
    localparam logic [WIDE_W-1:0] OFF_MASK = (WIDE_W'(1) << OFFSET_BITS) - WIDE_W'(1);

    pwag_pkg::pwag_cfg_t                    cfg;

    logic                                   s1_valid_reg, s1_valid_next;
    logic                                   s1_start_reg;
    logic [COORD_BITS-1:0]                  s1_row_reg;
    logic [COORD_BITS-1:0]                  s1_col_reg;
    logic [pwag_pkg::VALUE_BITS-1:0]        s1_value_reg;

    logic                                   out_valid_reg, out_valid_next;
    logic [pwag_pkg::ADDR_BITS-1:0]         out_addr_reg;
    logic [pwag_pkg::DATA_BITS-1:0]         out_data_reg;
    logic [pwag_pkg::COUNT_BITS-1:0]        out_count_reg;
    logic                                   out_done_reg;

    logic [pwag_pkg::COUNT_BITS-1:0]        write_count_reg, write_count_next;
    logic [pwag_pkg::FRAME_BITS-1:0]        frame_count_reg, frame_count_next;

    logic                                   out_free;
    logic                                   s1_adv;
    logic                                   in_acc;
    logic [PROD_W-1:0]                      prod;
    logic [SUM_W-1:0]                       sum;
    logic [WIDE_W-1:0]                      offset_wide;
    logic [WIDE_W-1:0]                      addr_wide;
    logic [pwag_pkg::COUNT_BITS-1:0]        cnt_base;
    logic [pwag_pkg::COUNT_BITS-1:0]        cnt_inc;
    logic                                   cnt_done;

    // configuration registers
    pwag_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_acc   = s_tvalid && s_tready;

    // byte offset of the pixel within the frame buffer
    assign prod        = PROD_W'(s1_row_reg) * PROD_W'(cfg.image_width);
    assign sum         = SUM_W'(prod) + SUM_W'(s1_col_reg);
    assign offset_wide = WIDE_W'({sum, 2'b00}) & OFF_MASK;
    assign addr_wide   = (WIDE_W'(cfg.base_high[cfg.active_buffer]) << OFFSET_BITS)
                         | offset_wide;

    // write count, cleared by image start before the increment
    assign cnt_base = s1_start_reg ? '0 : write_count_reg;
    assign cnt_inc  = cnt_base + pwag_pkg::COUNT_BITS'(1);
    assign cnt_done = (cnt_inc == cfg.frame_pixels);

    // next state
    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        out_valid_next   = out_valid_reg;
        write_count_next = write_count_reg;
        frame_count_next = frame_count_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next   = 1'b1;
            write_count_next = cnt_inc;
            if (cnt_done)
            begin
                frame_count_next = frame_count_reg + pwag_pkg::FRAME_BITS'(1);
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            write_count_reg <= '0;
            frame_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            write_count_reg <= write_count_next;
            frame_count_reg <= frame_count_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_start_reg <= s_tuser;
            s1_row_reg   <= s_tdata[ROW_LO +: COORD_BITS];
            s1_col_reg   <= s_tdata[COL_LO +: COORD_BITS];
            s1_value_reg <= s_tdata[VAL_LO +: pwag_pkg::VALUE_BITS];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_addr_reg  <= addr_wide[pwag_pkg::ADDR_BITS-1:0];
            out_data_reg  <= {frame_count_reg, s1_value_reg};
            out_count_reg <= cnt_inc;
            out_done_reg  <= cnt_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_data_reg, out_addr_reg};
    assign m_tuser  = out_done_reg;

    // checks
    `ASSERT_NEXT(a_count_step, clk, rst_n, s1_adv && !s1_start_reg,
                 write_count_reg == $past(write_count_reg) + 32'd1)
    `ASSERT_NEXT(a_count_restart, clk, rst_n, s1_adv && s1_start_reg,
                 write_count_reg == 32'd1)
    `ASSERT_NEXT(a_frame_hold, clk, rst_n, !(s1_adv && cnt_done),
                 $stable(frame_count_reg))
    `ASSERT_ALWAYS(a_stall_full, clk, rst_n,
                   !s_tready |-> (s1_valid_reg && out_valid_reg && !m_tready))

endmodule

FILE: bench/tb_pixel_write_address_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_write_address_generator
// Self-checking bench for the pixel write address generator
// ----------------------------------------------------------------------------
// Pixels go in on the slave stream and every accepted pixel is run through a
// local model of the address, data and frame counting logic. The expected
// writes wait in a queue, and each write that leaves the master stream is
// compared field by field with the oldest one. Registers are written over the
// APB port between phases and read back. Directed tests cover the field
// extremes, all four buffers, the start flag, a zero frame total, a long
// output stall and the frame counter wrap. Random raster images with some
// noise follow, with random idling on both streams, and a full drain.
// ----------------------------------------------------------------------------
module tb_pixel_write_address_generator;

    localparam int COORD_BITS    = pwag_pkg::COORD_BITS_DEF;
    localparam int OFFSET_BITS   = pwag_pkg::OFFSET_BITS_DEF;
    localparam int IN_TDATA_BITS = ((2*COORD_BITS+pwag_pkg::VALUE_BITS+7)/8)*8;
    localparam int FILL_BITS     = IN_TDATA_BITS - 2*COORD_BITS - pwag_pkg::VALUE_BITS;
    localparam int DRAIN_CYCLES  = 4;
    localparam int LONG_HOLD     = 150;
    localparam int RANDOM_ITEMS  = 250;
    localparam int WRAP_ITEMS    = 300;
    localparam logic [pwag_pkg::REG_IDX_BITS-1:0] REG_UNUSED_IDX = 3'd7;

    typedef struct {
        logic [pwag_pkg::ADDR_BITS-1:0]  address;
        logic [pwag_pkg::DATA_BITS-1:0]  data;
        logic [pwag_pkg::COUNT_BITS-1:0] count;
        logic                            done;
    } pixel_write_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  s_tvalid;
    logic                                  s_tready;
    // pixel_row, pixel_col, pixel_value, zero fill
    logic [IN_TDATA_BITS-1:0]              s_tdata;
    // image_start
    logic                                  s_tuser;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    // write_address, write_data, pixels_done
    logic [pwag_pkg::OUT_TDATA_BITS-1:0]   m_tdata;
    // frame_done
    logic                                  m_tuser;
    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [pwag_pkg::APB_ADDR_BITS-1:0]    paddr;
    logic [pwag_pkg::APB_DATA_BITS-1:0]    pwdata;
    logic [pwag_pkg::APB_DATA_BITS-1:0]    prdata;
    logic                                  pready;

    // local copy of the configuration and of the counters
    logic [pwag_pkg::BASE_BITS-1:0]    shadow_base [pwag_pkg::NUM_BUFS];
    logic [pwag_pkg::BUF_SEL_BITS-1:0] shadow_active;
    logic [pwag_pkg::WIDTH_BITS-1:0]   shadow_width;
    logic [pwag_pkg::COUNT_BITS-1:0]   shadow_total;
    logic [pwag_pkg::COUNT_BITS-1:0]   model_write_count;
    logic [pwag_pkg::FRAME_BITS-1:0]   model_frame_count;

    pixel_write_t pending_writes [$];
    pixel_write_t oldest_write;
    int           errors;
    bit           tx_idle_on;
    bit           rx_idle_on;
    bit           long_hold_req;
    int           hold_left;

    pixel_write_address_generator u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always #5 clk = ~clk;

    // run time limit
    initial
    begin
        #5_000_000;
        $display("tb_pixel_write_address_generator NOT OK");
        $finish;
    end

    // idle length: mostly short, a few long
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // register contents after a write, masked to the register width
    function automatic logic [pwag_pkg::APB_DATA_BITS-1:0] register_value(
        input logic [pwag_pkg::REG_IDX_BITS-1:0] idx);
        case (idx)
            pwag_pkg::REG_BASE_HIGH_0, pwag_pkg::REG_BASE_HIGH_1,
            pwag_pkg::REG_BASE_HIGH_2, pwag_pkg::REG_BASE_HIGH_3:
                return pwag_pkg::APB_DATA_BITS'(shadow_base[idx[1:0]]);
            pwag_pkg::REG_ACTIVE_BUFFER:
                return pwag_pkg::APB_DATA_BITS'(shadow_active);
            pwag_pkg::REG_IMAGE_WIDTH:
                return pwag_pkg::APB_DATA_BITS'(shadow_width);
            pwag_pkg::REG_FRAME_PIXELS:
                return pwag_pkg::APB_DATA_BITS'(shadow_total);
            default:
                return '0;
        endcase
    endfunction

    // memory write expected for one pixel, counters updated
    task automatic predict_pixel_write(input logic start,
                                       input logic [COORD_BITS-1:0] row,
                                       input logic [COORD_BITS-1:0] col,
                                       input logic [pwag_pkg::VALUE_BITS-1:0] value);
        logic [31:0]  offset;
        pixel_write_t w;
        if (start)
            model_write_count = '0;
        offset = ((32'(row) * 32'(shadow_width)) + 32'(col)) << 2;
        w.address = {shadow_base[shadow_active], offset[OFFSET_BITS-1:0]};
        w.data    = {model_frame_count, value};
        model_write_count = model_write_count + 1'b1;
        w.count = model_write_count;
        w.done  = (model_write_count == shadow_total);
        if (w.done)
            model_frame_count = model_frame_count + 1'b1;
        pending_writes.push_back(w);
    endtask

    // offer one pixel item and wait until it is taken
    task automatic send_pixel(input logic start,
                              input logic [COORD_BITS-1:0] row,
                              input logic [COORD_BITS-1:0] col,
                              input logic [pwag_pkg::VALUE_BITS-1:0] value);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {{FILL_BITS{1'b0}}, value, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pixel_write(start, row, col, value);
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 99) < 30)
            gap = idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop offering and wait until every expected write has left
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb transfer, setup then access
    task automatic apb_transfer(input logic write,
                                input logic [pwag_pkg::REG_IDX_BITS-1:0] idx,
                                input logic [pwag_pkg::APB_DATA_BITS-1:0] wdata,
                                output logic [pwag_pkg::APB_DATA_BITS-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read a register back and compare with the local copy
    task automatic check_register(input logic [pwag_pkg::REG_IDX_BITS-1:0] idx);
        logic [pwag_pkg::APB_DATA_BITS-1:0] rdata;
        apb_transfer(1'b0, idx, '0, rdata);
        if (rdata !== register_value(idx))
        begin
            errors++;
            $display("%0t: register %0d read expected %h actual %h",
                     $time, idx, register_value(idx), rdata);
        end
    endtask

    // register write while the block is idle, then read back
    task automatic write_register(input logic [pwag_pkg::REG_IDX_BITS-1:0] idx,
                                  input logic [pwag_pkg::APB_DATA_BITS-1:0] value);
        logic [pwag_pkg::APB_DATA_BITS-1:0] rdata;
        wait_drained();
        apb_transfer(1'b1, idx, value, rdata);
        case (idx)
            pwag_pkg::REG_BASE_HIGH_0, pwag_pkg::REG_BASE_HIGH_1,
            pwag_pkg::REG_BASE_HIGH_2, pwag_pkg::REG_BASE_HIGH_3:
                shadow_base[idx[1:0]] = value[pwag_pkg::BASE_BITS-1:0];
            pwag_pkg::REG_ACTIVE_BUFFER:
                shadow_active = value[pwag_pkg::BUF_SEL_BITS-1:0];
            pwag_pkg::REG_IMAGE_WIDTH:
                shadow_width  = value[pwag_pkg::WIDTH_BITS-1:0];
            pwag_pkg::REG_FRAME_PIXELS:
                shadow_total  = value;
            default:
                ;
        endcase
        if (idx != REG_UNUSED_IDX)
            check_register(idx);
    endtask

    // receiver: random stalls and a requested long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD - 1;
            m_tready     <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 99) < 20)
        begin
            hold_left = idle_length() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // compare each write item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_writes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected write expected none actual %h %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                oldest_write = pending_writes.pop_front();
                if (m_tdata[pwag_pkg::ADDR_BITS-1:0] !== oldest_write.address)
                begin
                    errors++;
                    $display("%0t: write_address expected %h actual %h", $time,
                             oldest_write.address, m_tdata[pwag_pkg::ADDR_BITS-1:0]);
                end
                if (m_tdata[pwag_pkg::ADDR_BITS +: pwag_pkg::DATA_BITS]
                    !== oldest_write.data)
                begin
                    errors++;
                    $display("%0t: write_data expected %h actual %h", $time,
                             oldest_write.data,
                             m_tdata[pwag_pkg::ADDR_BITS +: pwag_pkg::DATA_BITS]);
                end
                if (m_tdata[pwag_pkg::ADDR_BITS+pwag_pkg::DATA_BITS +: pwag_pkg::COUNT_BITS]
                    !== oldest_write.count)
                begin
                    errors++;
                    $display("%0t: pixels_done expected %h actual %h", $time,
                             oldest_write.count,
                             m_tdata[pwag_pkg::ADDR_BITS+pwag_pkg::DATA_BITS +:
                                     pwag_pkg::COUNT_BITS]);
                end
                if (m_tuser !== oldest_write.done)
                begin
                    errors++;
                    $display("%0t: frame_done expected %b actual %b", $time,
                             oldest_write.done, m_tuser);
                end
            end
        end
    end

    // every register written with extremes and garbage above its width
    task automatic test_register_access();
        logic [pwag_pkg::REG_IDX_BITS-1:0] idx;
        for (int i = 0; i <= pwag_pkg::REG_FRAME_PIXELS; i++)
        begin
            idx = pwag_pkg::REG_IDX_BITS'(i);
            write_register(idx, '1);
            write_register(idx, '0);
            write_register(idx, $urandom());
        end
        // unmapped index leaves everything as it was
        write_register(REG_UNUSED_IDX, '1);
        for (int i = 0; i <= pwag_pkg::REG_FRAME_PIXELS; i++)
            check_register(pwag_pkg::REG_IDX_BITS'(i));
    endtask

    // coordinate and value extremes, all buffers, offset overflow
    task automatic test_field_extremes();
        write_register(pwag_pkg::REG_BASE_HIGH_0, 32'h0000_00FF);
        write_register(pwag_pkg::REG_BASE_HIGH_1, 32'h0000_0000);
        write_register(pwag_pkg::REG_BASE_HIGH_2, 32'h0000_00A5);
        write_register(pwag_pkg::REG_BASE_HIGH_3, 32'h0000_005A);
        write_register(pwag_pkg::REG_IMAGE_WIDTH, 32'h0000_0FFF);
        write_register(pwag_pkg::REG_FRAME_PIXELS, 32'hFFFF_FFFF);
        for (int b = 0; b < pwag_pkg::NUM_BUFS; b++)
        begin
            write_register(pwag_pkg::REG_ACTIVE_BUFFER, b);
            send_pixel(1'b1, '1, '1, '1);
            send_pixel(1'b0, '0, '0, '0);
        end
        send_pixel(1'b0, 11'd1, 11'd0, 24'h5A5A5A);
        // zero width leaves only the column in the offset
        write_register(pwag_pkg::REG_IMAGE_WIDTH, 32'h0000_0000);
        send_pixel(1'b0, '1, 11'd5, 24'hA5A5A5);
    endtask

    // start flag clears the count, done at the frame total
    task automatic test_image_start();
        write_register(pwag_pkg::REG_IMAGE_WIDTH, 32'd4);
        write_register(pwag_pkg::REG_FRAME_PIXELS, 32'd3);
        send_pixel(1'b0, 11'd0, 11'd0, 24'h000001);
        send_pixel(1'b0, 11'd0, 11'd1, 24'h000002);
        for (int i = 0; i < 4; i++)
            send_pixel(i == 0, 11'd1, 11'(i), pwag_pkg::VALUE_BITS'(24'h100000 + i));
        send_pixel(1'b1, 11'd2, 11'd0, 24'h200000);
        send_pixel(1'b0, 11'd2, 11'd1, 24'h200001);
    endtask

    // zero frame total never completes a frame short of a count wrap
    task automatic test_zero_frame_total();
        write_register(pwag_pkg::REG_FRAME_PIXELS, 32'd0);
        send_pixel(1'b1, 11'd3, 11'd3,
                   pwag_pkg::VALUE_BITS'($urandom_range(0, 24'hFFFFFF)));
        send_pixel(1'b0, 11'd3, 11'd4,
                   pwag_pkg::VALUE_BITS'($urandom_range(0, 24'hFFFFFF)));
        send_pixel(1'b0, 11'd3, 11'd5,
                   pwag_pkg::VALUE_BITS'($urandom_range(0, 24'hFFFFFF)));
    endtask

    // long output hold-off while the input keeps offering
    task automatic test_backpressure();
        write_register(pwag_pkg::REG_IMAGE_WIDTH, 32'd8);
        write_register(pwag_pkg::REG_FRAME_PIXELS, 32'd16);
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_pixel(i == 0, 11'(i / 8), 11'(i % 8),
                       pwag_pkg::VALUE_BITS'($urandom_range(0, 24'hFFFFFF)));
        // sender pauses until the block has emptied
        wait_drained();
        for (int i = 0; i < 4; i++)
            send_pixel(1'b0, 11'd3, 11'(i),
                       pwag_pkg::VALUE_BITS'($urandom_range(0, 24'hFFFFFF)));
    endtask

    // one-pixel frames so the frame counter runs past 255
    task automatic test_frame_counter_wrap();
        write_register(pwag_pkg::REG_FRAME_PIXELS, 32'd1);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < WRAP_ITEMS; i++)
            send_pixel($urandom_range(0, 19) != 0,
                       COORD_BITS'($urandom_range(0, 2047)),
                       COORD_BITS'($urandom_range(0, 2047)),
                       pwag_pkg::VALUE_BITS'($urandom_range(0, 24'hFFFFFF)));
    endtask

    // raster images with random content, origins and settings, plus noise
    task automatic test_random_images();
        int sent;
        int cols;
        int rows;
        int row0;
        int col0;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            cols = $urandom_range(1, 12);
            rows = $urandom_range(1, 8);
            for (int b = 0; b < pwag_pkg::NUM_BUFS; b++)
                if ($urandom_range(0, 1))
                    write_register(pwag_pkg::REG_IDX_BITS'(b), $urandom());
            write_register(pwag_pkg::REG_ACTIVE_BUFFER, $urandom());
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_register(pwag_pkg::REG_IMAGE_WIDTH, 32'h0000_0FFF);
            else if (pick == 1)
                write_register(pwag_pkg::REG_IMAGE_WIDTH, 32'h0000_0000);
            else if (pick == 2)
                write_register(pwag_pkg::REG_IMAGE_WIDTH, $urandom());
            else
                write_register(pwag_pkg::REG_IMAGE_WIDTH, cols);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_register(pwag_pkg::REG_FRAME_PIXELS, 32'd0);
            else if (pick == 1)
                write_register(pwag_pkg::REG_FRAME_PIXELS, 32'hFFFF_FFFF);
            else if (pick == 2)
                write_register(pwag_pkg::REG_FRAME_PIXELS, $urandom_range(1, 40));
            else
                write_register(pwag_pkg::REG_FRAME_PIXELS, cols * rows);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 4))
            begin
                row0 = $urandom_range(0, 2048 - rows);
                col0 = $urandom_range(0, 2048 - cols);
                for (int r = 0; r < rows; r++)
                    for (int c = 0; c < cols; c++)
                    begin
                        if ($urandom_range(0, 99) < 8)
                            send_pixel($urandom_range(0, 1) != 0,
                                       COORD_BITS'($urandom_range(0, 2047)),
                                       COORD_BITS'($urandom_range(0, 2047)),
                                       pwag_pkg::VALUE_BITS'($urandom_range(0, 24'hFFFFFF)));
                        else
                            send_pixel(r == 0 && c == 0, COORD_BITS'(row0 + r),
                                       COORD_BITS'(col0 + c),
                                       pwag_pkg::VALUE_BITS'($urandom_range(0, 24'hFFFFFF)));
                        sent++;
                    end
            end
        end
    endtask

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        errors        = 0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        long_hold_req = 1'b0;
        hold_left     = 0;
        for (int b = 0; b < pwag_pkg::NUM_BUFS; b++)
            shadow_base[b] = '0;
        shadow_active     = '0;
        shadow_width      = '0;
        shadow_total      = '0;
        model_write_count = '0;
        model_frame_count = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_access();
        test_field_extremes();
        test_image_start();
        test_zero_frame_total();
        test_backpressure();
        test_frame_counter_wrap();
        test_random_images();
        wait_drained();

        if (errors == 0)
            $display("tb_pixel_write_address_generator OK");
        else
            $display("tb_pixel_write_address_generator NOT OK");
        $finish;
    end

endmodule
